>>> sv/spt_pkg.sv
// Shared types, constants and helper functions for the stereo point triangulation block.
// Holds the lane word used by the pipelined divider, its step function and the saturation logic.
// No dependencies.
`default_nettype none

package spt_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int BASE_W  = 20;
    localparam int NUM_W   = 37;   // baseline * 17-bit magnitude
    localparam int DEN_W   = 17;   // 2 * 16-bit disparity magnitude
    localparam int Q_W     = 32;
    localparam int CFG_AW  = 2;

    // divider pipeline: quotient bits resolved per register stage
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = Q_W / STEP_BITS;
    // prep, multiply, divider setup, divider steps, output
    localparam int PIPE_DEPTH = DIV_STAGES + 4;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_BASELINE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FOCAL    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 2'd2;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 2'd3;

    localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // stage after input prep
    typedef struct packed {
        logic                 dzero;
        logic                 dneg;
        logic [COORD_W-1:0]   dmag;
        logic                 xneg;
        logic [COORD_W-1:0]   xmag;
        logic                 yneg;
        logic [COORD_W:0]     ymag;
    } prep_t;

    // stage after the multipliers
    typedef struct packed {
        logic                 dzero;
        logic                 dneg;
        logic [COORD_W-1:0]   dmag;
        logic                 xneg;
        logic                 yneg;
        logic [NUM_W-1:0]     num_x;
        logic [NUM_W-1:0]     num_y;
        logic [NUM_W-1:0]     num_z;
    } prod_t;

    // one restoring-division lane; bits holds the low numerator bits and
    // collects quotient bits from the bottom as they shift out
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   bits;
        logic [DEN_W-1:0] den;
        logic             ovf;
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic  dzero;
        lane_t x;
        lane_t y;
        lane_t z;
    } div_item_t;

    typedef struct packed {
        logic           sat;
        logic [Q_W-1:0] value;
    } sat_res_t;

    function automatic lane_t lane_setup(input logic [NUM_W-1:0] num,
                                         input logic [DEN_W-1:0] den,
                                         input logic neg);
        lane_t l;
        l.den  = den;
        l.neg  = neg;
        // quotient needs more than 32 bits when the top numerator bits reach den
        l.ovf  = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]} >= den;
        l.rem  = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
        l.bits = num[Q_W-1:0];
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l);
        lane_t      r;
        logic [DEN_W:0] trial;
        r = l;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {r.rem, r.bits[Q_W-1]};
            if (trial >= {1'b0, r.den}) begin
                trial = trial - {1'b0, r.den};
                r.bits = {r.bits[Q_W-2:0], 1'b1};
            end else begin
                r.bits = {r.bits[Q_W-2:0], 1'b0};
            end
            r.rem = trial[DEN_W-1:0];
        end
        return r;
    endfunction

    function automatic div_item_t item_step(input div_item_t d);
        div_item_t r;
        r.dzero = d.dzero;
        r.x = lane_step(d.x);
        r.y = lane_step(d.y);
        r.z = lane_step(d.z);
        return r;
    endfunction

    // apply sign and clamp to signed Q16.16
    function automatic sat_res_t lane_finish(input lane_t l);
        sat_res_t s;
        if (l.neg) begin
            if (l.ovf || l.bits > NEG_LIMIT) begin
                s.sat   = 1'b1;
                s.value = NEG_LIMIT;
            end else begin
                s.sat   = 1'b0;
                s.value = Q_W'(0) - l.bits;
            end
        end else begin
            if (l.ovf || l.bits > POS_LIMIT) begin
                s.sat   = 1'b1;
                s.value = POS_LIMIT;
            end else begin
                s.sat   = 1'b0;
                s.value = l.bits;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/stereo_point_triangulation_top.sv
// Stereo point triangulation: one matched keypoint pair in, one 3-D point (Q16.16) out.
// Throughput is one word per cycle while m_tready holds high; the pipeline depth is set
// mostly by the 32-bit restoring divider, cut into 8 stages of 4 bits.
// Each stage holds while the stage after it is full and stalled; bubbles collapse.
// Synchronous active-low reset clears the stage valid bits and the configuration registers.
// Depends on spt_pkg.
`default_nettype none

module stereo_point_triangulation_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [19:0]  cfg_wdata,
    // input keypoint pair
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // left_u, left_v, right_u, right_v
    // output point
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // point_x, point_y, point_z
    output logic              m_tuser    // invalid
);

    localparam int CW = spt_pkg::COORD_W;
    localparam int DEPTH = spt_pkg::PIPE_DEPTH;
    localparam int NDIV = spt_pkg::DIV_STAGES;

    // configuration registers
    logic [spt_pkg::BASE_W-1:0] baseline_reg;
    logic [CW-1:0]              focal_reg;
    logic [CW-1:0]              center_x_reg;
    logic [CW-1:0]              center_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            focal_reg    <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                spt_pkg::REG_BASELINE: baseline_reg <= cfg_wdata;
                spt_pkg::REG_FOCAL:    focal_reg    <= cfg_wdata[CW-1:0];
                spt_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata[CW-1:0];
                spt_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake: a stage takes a word when it is empty or its word moves on
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [DEPTH:0]   ready;

    assign ready[DEPTH] = m_tready;
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_ready
            assign ready[g] = !valid_reg[g] || ready[g+1];
        end
    endgenerate

    always_comb begin
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < DEPTH; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[DEPTH-1];

    // stage 0: disparity and offset magnitudes with signs
    logic [CW-1:0]  lu, lv, ru, rv;
    logic [CW:0]    vsum, cy2;
    logic           xneg_raw, yneg_raw;
    spt_pkg::prep_t prep_next, prep_reg;

    always_comb begin
        lu = s_tdata[15:0];
        lv = s_tdata[31:16];
        ru = s_tdata[47:32];
        rv = s_tdata[63:48];
        vsum = {1'b0, lv} + {1'b0, rv};
        cy2  = {center_y_reg, 1'b0};
        xneg_raw = center_x_reg < lu;
        yneg_raw = cy2 < vsum;
        prep_next.dzero = ru == lu;
        prep_next.dneg  = ru < lu;
        prep_next.dmag  = (ru < lu) ? lu - ru : ru - lu;
        prep_next.xmag  = xneg_raw ? lu - center_x_reg : center_x_reg - lu;
        prep_next.ymag  = yneg_raw ? vsum - cy2 : cy2 - vsum;
        prep_next.xneg  = xneg_raw ^ (ru < lu);
        prep_next.yneg  = yneg_raw ^ (ru < lu);
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            prep_reg <= prep_next;
        end
    end

    // stage 1: baseline products
    spt_pkg::prod_t prod_next, prod_reg;

    always_comb begin
        prod_next.dzero = prep_reg.dzero;
        prod_next.dneg  = prep_reg.dneg;
        prod_next.dmag  = prep_reg.dmag;
        prod_next.xneg  = prep_reg.xneg;
        prod_next.yneg  = prep_reg.yneg;
        prod_next.num_x = spt_pkg::NUM_W'(baseline_reg * prep_reg.xmag);
        prod_next.num_y = spt_pkg::NUM_W'(baseline_reg * prep_reg.ymag);
        prod_next.num_z = spt_pkg::NUM_W'(baseline_reg * focal_reg);
    end

    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: divider setup; stages 3 .. 2+NDIV: four quotient bits each
    spt_pkg::div_item_t div_reg [0:NDIV];
    spt_pkg::div_item_t div_next [0:NDIV];

    always_comb begin
        div_next[0].dzero = prod_reg.dzero;
        div_next[0].x = spt_pkg::lane_setup(prod_reg.num_x, {1'b0, prod_reg.dmag},
                                            prod_reg.xneg);
        // Y divides by twice the disparity (row average has one extra fraction bit)
        div_next[0].y = spt_pkg::lane_setup(prod_reg.num_y, {prod_reg.dmag, 1'b0},
                                            prod_reg.yneg);
        div_next[0].z = spt_pkg::lane_setup(prod_reg.num_z, {1'b0, prod_reg.dmag},
                                            prod_reg.dneg);
        for (int k = 1; k <= NDIV; k++) begin
            div_next[k] = spt_pkg::item_step(div_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= NDIV; k++) begin
            if (ready[k+2]) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // last stage: sign, clamp, zero-disparity override
    spt_pkg::sat_res_t sx, sy, sz;
    logic [95:0] tdata_next, tdata_reg;
    logic        tuser_next, tuser_reg;

    always_comb begin
        sx = spt_pkg::lane_finish(div_reg[NDIV].x);
        sy = spt_pkg::lane_finish(div_reg[NDIV].y);
        sz = spt_pkg::lane_finish(div_reg[NDIV].z);
        if (div_reg[NDIV].dzero) begin
            tdata_next = '0;
            tuser_next = 1'b1;
        end else begin
            tdata_next = {sz.value, sy.value, sx.value};
            tuser_next = sx.sat | sy.sat | sz.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[DEPTH-1]) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for stereo_point_triangulation_top: drives keypoint pairs and configuration,
// predicts every 3-D point in a scoreboard class and checks the result stream word by word.
// Depends on spt_pkg and the top-level RTL.

module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 125;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * spt_pkg::PIPE_DEPTH + 8;
    localparam int MAX_REPORTS  = 10;

    // packed so that left_u sits in the low bits of s_tdata
    typedef struct packed {
        logic [spt_pkg::COORD_W-1:0] right_v;
        logic [spt_pkg::COORD_W-1:0] right_u;
        logic [spt_pkg::COORD_W-1:0] left_v;
        logic [spt_pkg::COORD_W-1:0] left_u;
    } pair_t;

    // matches {m_tuser, m_tdata}
    typedef struct packed {
        logic                    invalid;
        logic [spt_pkg::Q_W-1:0] pz;
        logic [spt_pkg::Q_W-1:0] py;
        logic [spt_pkg::Q_W-1:0] px;
    } point_t;

    class point_scoreboard;
        point_t      expected_points[$];
        logic [63:0] baseline = '0;
        logic [63:0] focal    = '0;
        logic [63:0] center_x = '0;
        logic [63:0] center_y = '0;
        int          errors   = 0;

        function void set_register(logic [spt_pkg::CFG_AW-1:0] idx,
                                   logic [spt_pkg::BASE_W-1:0] value);
            case (idx)
                spt_pkg::REG_BASELINE: baseline = 64'(value);
                spt_pkg::REG_FOCAL:    focal    = 64'(value[spt_pkg::COORD_W-1:0]);
                spt_pkg::REG_CENTER_X: center_x = 64'(value[spt_pkg::COORD_W-1:0]);
                spt_pkg::REG_CENTER_Y: center_y = 64'(value[spt_pkg::COORD_W-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // truncating divide of a magnitude, then sign and clamp to Q16.16
        function logic [spt_pkg::Q_W-1:0] clamp_quotient(bit neg, logic [63:0] num,
                                                         logic [63:0] den, inout bit sat);
            logic [63:0] q;
            q = num / den;
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    q = 64'h8000_0000;
                    sat = 1'b1;
                end
                q = 64'd0 - q;
            end else if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return q[spt_pkg::Q_W-1:0];
        endfunction

        function point_t triangulate(pair_t p);
            point_t      pt;
            longint      lu, lv, ru, rv, du, ux, uy;
            logic [63:0] dmag, xmag, ymag;
            bit          dneg, sat;
            pt  = '0;
            sat = 1'b0;
            lu  = p.left_u;
            lv  = p.left_v;
            ru  = p.right_u;
            rv  = p.right_v;
            du  = ru - lu;
            ux  = longint'(center_x) - lu;
            uy  = 2 * longint'(center_y) - (lv + rv);
            if (du == 0) begin
                pt.invalid = 1'b1;
                return pt;
            end
            dneg = du < 0;
            dmag = dneg ? -du : du;
            xmag = (ux < 0) ? -ux : ux;
            ymag = (uy < 0) ? -uy : uy;
            pt.px = clamp_quotient((ux < 0) != dneg, baseline * xmag, dmag, sat);
            // row average keeps a half-pixel bit, so the divisor doubles
            pt.py = clamp_quotient((uy < 0) != dneg, baseline * ymag, dmag << 1, sat);
            pt.pz = clamp_quotient(dneg, baseline * focal, dmag, sat);
            pt.invalid = sat;
            return pt;
        endfunction

        function void note_pair(pair_t p);
            expected_points = {expected_points, triangulate(p)};
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0) begin
                flag($sformatf("unexpected point word: x=%h y=%h z=%h invalid=%b",
                               got.px, got.py, got.pz, got.invalid));
                return;
            end
            want = expected_points.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                got.invalid !== want.invalid)
                flag($sformatf({"point mismatch: exp x=%h y=%h z=%h invalid=%b, ",
                                "got x=%h y=%h z=%h invalid=%b"},
                               want.px, want.py, want.pz, want.invalid,
                               got.px, got.py, got.pz, got.invalid));
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [spt_pkg::CFG_AW-1:0] cfg_addr;
    logic [spt_pkg::BASE_W-1:0] cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [63:0]                s_tdata;    // left_u, left_v, right_u, right_v
    logic                       m_tvalid;
    logic                       m_tready;
    logic [95:0]                m_tdata;    // point_x, point_y, point_z
    logic                       m_tuser;    // invalid

    point_scoreboard sb = new();
    bit              burst_mode    = 1'b0;
    bit              long_hold_req = 1'b0;
    int unsigned     idle_cycles   = 0;

    stereo_point_triangulation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = spt_pkg::REG_BASELINE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
    end

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_point(point_t'({m_tuser, m_tdata}));
    end

    // watchdog: cycles with no word moving on either side and no configuration write
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, 5);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // entered and left at a falling edge
    task automatic send_pair(pair_t p);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(p);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic put_reg(logic [spt_pkg::CFG_AW-1:0] idx,
                           logic [spt_pkg::BASE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic load_config(logic [spt_pkg::BASE_W-1:0] base,
                               logic [spt_pkg::BASE_W-1:0] focal,
                               logic [spt_pkg::BASE_W-1:0] cx,
                               logic [spt_pkg::BASE_W-1:0] cy);
        put_reg(spt_pkg::REG_BASELINE, base);
        put_reg(spt_pkg::REG_FOCAL, focal);
        put_reg(spt_pkg::REG_CENTER_X, cx);
        put_reg(spt_pkg::REG_CENTER_Y, cy);
        cfg_we <= 1'b0;
    endtask

    function automatic pair_t keypoint_pair(logic [15:0] lu, logic [15:0] lv,
                                            logic [15:0] ru, logic [15:0] rv);
        pair_t p;
        p.left_u  = lu;
        p.left_v  = lv;
        p.right_u = ru;
        p.right_v = rv;
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t       p;
        logic [15:0] corner_vals [5] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000};
        p = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            4, 5, 6, 7: begin
                // plausible match: small disparity of either sign, rows close
                p.right_u = p.left_u + 16'($urandom_range(0, 128)) - 16'd64;
                p.right_v = p.left_v + 16'($urandom_range(0, 8)) - 16'd4;
            end
            8: p.right_u = p.left_u;
            9: begin
                p.left_u  = corner_vals[$urandom_range(0, 4)];
                p.left_v  = corner_vals[$urandom_range(0, 4)];
                p.right_u = corner_vals[$urandom_range(0, 4)];
                p.right_v = corner_vals[$urandom_range(0, 4)];
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // registers still at reset: zero baseline
        send_pair(keypoint_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pair(keypoint_pair(16'h1234, 16'h5678, 16'h1240, 16'h5679));

        // b*f = 2^31: unit disparity lands exactly on the negative limit, clamps on positive
        wait_idle();
        load_config(20'h80000, 20'h01000, 20'h08000, 20'h08000);
        send_pair(keypoint_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
        send_pair(keypoint_pair(16'h8000, 16'h8000, 16'h8001, 16'h8000));
        send_pair(keypoint_pair(16'h8000, 16'h8000, 16'h8002, 16'h8001));
        send_pair(keypoint_pair(16'h1000, 16'h8000, 16'h1001, 16'h8000));
        send_pair(keypoint_pair(16'h1001, 16'h8000, 16'h1000, 16'h8000));
        send_pair(keypoint_pair(16'h9000, 16'h0000, 16'h9400, 16'hFFFF));

        // all registers at max; 16-bit ones see the upper write bits masked off
        wait_idle();
        load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_pair(keypoint_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_pair(keypoint_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
        send_pair(keypoint_pair(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        send_pair(keypoint_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pair(keypoint_pair(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF));

        // tiny values: truncation toward zero on negative quotients, odd row sum
        wait_idle();
        load_config(20'd3, 20'd1, 20'd0, 20'd0);
        send_pair(keypoint_pair(16'd5, 16'd1, 16'd7, 16'd0));
        send_pair(keypoint_pair(16'd7, 16'd0, 16'd5, 16'd1));
        send_pair(keypoint_pair(16'd0, 16'd3, 16'd3, 16'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                1: load_config(20'h00000, 20'h00000, 20'h00000, 20'h00000);
                2, 3: load_config(20'($urandom_range(1, 20'h20000)), 20'($urandom),
                                  20'($urandom), 20'($urandom));
                default: load_config(20'($urandom), 20'($urandom),
                                     20'($urandom), 20'($urandom));
            endcase
            // fill the pipe against a stopped output
            if (ph == 3)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                send_pair(random_pair());
            end
        end

        burst_mode = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/spt_pkg.sv
sv/stereo_point_triangulation_top.sv
test/tb_top.sv
